// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the checker in this folder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define HLCC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define HLCC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/hlcc_pkg.sv =====
package hlcc_pkg;

    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    typedef logic [1:0] t_mode;
    typedef logic [4:0] t_chan;
    typedef logic [4:0] t_shift;
    typedef logic [8:0] t_sum;

    localparam t_mode MODE_PASS     = 2'd0;
    localparam t_mode MODE_HANDHELD = 2'd1;
    localparam t_mode MODE_ADVANCE  = 2'd2;

    localparam logic [2:0] REG_COLOR_MODE    = 3'd0;
    localparam logic [2:0] REG_RED_SHIFT     = 3'd1;
    localparam logic [2:0] REG_GREEN_SHIFT   = 3'd2;
    localparam logic [2:0] REG_BLUE_SHIFT    = 3'd3;
    localparam logic [2:0] REG_NARROW_OUTPUT = 3'd4;

    typedef struct packed {
        t_mode  color_mode;
        t_shift red_shift;
        t_shift green_shift;
        t_shift blue_shift;
        logic   narrow_output;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        color_mode:    MODE_PASS,
        red_shift:     5'd0,
        green_shift:   5'd5,
        blue_shift:    5'd10,
        narrow_output: 1'b0
    };

    // Brighten a channel: nonzero values below 16 gain 2, larger ones 3, capped at 30.
    function automatic t_chan boost(input t_chan c);
        logic [5:0] v;
        v = {1'b0, c};
        if (c != 5'd0) begin
            v = (c < 5'h10) ? 6'({1'b0, c} + 6'd2) : 6'({1'b0, c} + 6'd3);
        end
        if (v >= 6'h1F) begin
            v = 6'h1E;
        end
        return v[4:0];
    endfunction

    // Darken a channel: below 25 loses 4, otherwise 3, floored at zero.
    function automatic t_chan dim(input t_chan c);
        t_chan sub;
        sub = (c < 5'h19) ? 5'd4 : 5'd3;
        return (c > sub) ? 5'(c - sub) : 5'd0;
    endfunction

    // Divide by 14 through the reciprocal 2341 / 2^15; exact for sums up to 420.
    function automatic t_chan div14(input t_sum x);
        logic [19:0] prod;
        prod = 20'(x) * 20'd2341;
        return prod[19:15];
    endfunction

endpackage

// ===== rtl/core/hlcc_mix.sv =====
module hlcc_mix
    import hlcc_pkg::*;
(
    input  logic [15:0] i_color_word,
    input  t_cfg        i_cfg,
    output logic [31:0] o_pixel
);

    t_chan r0, g0, b0;
    t_chan ra, ga, ba;
    t_chan r, g, b;
    t_sum  sum_r, sum_g, sum_b;
    logic [31:0] pix;

    assign r0 = i_color_word[4:0];
    assign g0 = i_color_word[9:5];
    assign b0 = i_color_word[14:10];

    always_comb begin
        ra    = r0;
        ga    = g0;
        ba    = b0;
        sum_r = '0;
        sum_g = '0;
        sum_b = '0;
        r     = r0;
        g     = g0;
        b     = b0;
        case (i_cfg.color_mode)
            MODE_HANDHELD: begin
                ra    = boost(r0);
                ga    = boost(g0);
                ba    = boost(b0);
                sum_r = 9'(ra) * 9'd10 + 9'(ga) * 9'd3 + 9'(ba);
                sum_g = 9'(ga) * 9'd10 + 9'(ba) * 9'd2 + 9'(ra) * 9'd2;
                sum_b = 9'(ba) * 9'd10 + 9'(ra) * 9'd2 + 9'(ga) * 9'd2;
                r     = div14(sum_r);
                g     = div14(sum_g);
                b     = div14(sum_b);
            end
            MODE_ADVANCE: begin
                ra    = dim(r0);
                ga    = dim(g0);
                ba    = dim(b0);
                sum_r = 9'(ra) * 9'd12 + 9'(ga) + 9'(ba);
                sum_g = 9'(ga) * 9'd12 + 9'(ba) + 9'(ra);
                sum_b = 9'(ba) * 9'd12 + 9'(ra) + 9'(ga);
                r     = div14(sum_r);
                g     = div14(sum_g);
                b     = div14(sum_b);
            end
            default: begin
                // Passthrough, and the unused mode code behaves the same.
                r = r0;
                g = g0;
                b = b0;
            end
        endcase
    end

    // Bits shifted past bit 31 fall away.
    assign pix = (32'(r) << i_cfg.red_shift)
               | (32'(g) << i_cfg.green_shift)
               | (32'(b) << i_cfg.blue_shift);

    assign o_pixel = i_cfg.narrow_output ? {16'h0000, pix[15:0]} : pix;

endmodule

// ===== rtl/core/handheld_lcd_color_correction.sv =====
// RGB555 colour correction and pixel packing.
// Input channel: i_valid / o_stall with the colour word on i_color_word; a word
// is taken at a rising edge with i_valid high and o_stall low. Output channel:
// o_valid / i_stall with the packed pixel on o_pixel_out.
// Configuration goes through the APB port: mode at 0x00, red, green and blue
// shifts at 0x04, 0x08 and 0x0C, narrow output at 0x10. Registers may only be
// written while no word is in flight.
// An accepted word waits in the input register until the output register can
// take it; o_valid rises when the pixel is loaded there. There is one input
// register, then the correction, mixing and packing logic into the output
// register.
// Throughput is one word per clock unless the receiver stalls; the input and
// output registers each hold one word, so the block keeps taking words until
// both are full. When the receiver stalls, the output holds its pixel, the input
// register fills, and o_stall rises in the same cycle that i_stall finds both full.
// Synchronous reset empties both registers and restores the default
// configuration: passthrough, shifts 0/5/10, 32-bit output.
module handheld_lcd_color_correction
    import hlcc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [15:0]         i_color_word,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [31:0]         o_pixel_out
);

    t_cfg        r_cfg;
    logic        r_s1_vld;
    logic [15:0] r_s1_word;
    logic        r_o_vld;
    logic [31:0] r_o_pix;

    logic        s1_en;
    logic        s2_ld;
    logic        cfg_wr;
    logic [31:0] mix_pix;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_COLOR_MODE:    r_cfg.color_mode    <= pwdata[1:0];
                REG_RED_SHIFT:     r_cfg.red_shift     <= pwdata[4:0];
                REG_GREEN_SHIFT:   r_cfg.green_shift   <= pwdata[4:0];
                REG_BLUE_SHIFT:    r_cfg.blue_shift    <= pwdata[4:0];
                REG_NARROW_OUTPUT: r_cfg.narrow_output <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_COLOR_MODE:    prdata = 32'(r_cfg.color_mode);
            REG_RED_SHIFT:     prdata = 32'(r_cfg.red_shift);
            REG_GREEN_SHIFT:   prdata = 32'(r_cfg.green_shift);
            REG_BLUE_SHIFT:    prdata = 32'(r_cfg.blue_shift);
            REG_NARROW_OUTPUT: prdata = 32'(r_cfg.narrow_output);
            default:           prdata = '0;
        endcase
    end

    // The output register takes a word when it is empty or being drained.
    assign s2_ld   = r_s1_vld && (!r_o_vld || !i_stall);
    assign s1_en   = !r_s1_vld || s2_ld;
    assign o_stall = !s1_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            if (s1_en) begin
                r_s1_vld <= i_valid;
            end
            if (s2_ld) begin
                r_o_vld <= 1'b1;
            end else if (!i_stall) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_en && i_valid) begin
            r_s1_word <= i_color_word;
        end
        if (s2_ld) begin
            r_o_pix <= mix_pix;
        end
    end

    hlcc_mix u_mix (
        .i_color_word (r_s1_word),
        .i_cfg        (r_cfg),
        .o_pixel      (mix_pix)
    );

    assign o_valid     = r_o_vld;
    assign o_pixel_out = r_o_pix;

endmodule

// ===== rtl/core/hlcc_checker.sv =====
`include "assert_macros.svh"

module hlcc_checker
    import hlcc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_pixel_out
);

    // Reset leaves no pixel on the output.
    `HLCC_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_valid, "output valid after reset")

    // A stalled pixel stays put.
    `HLCC_ASSERT(a_out_hold, i_clk, i_rst_n,
        o_valid && i_stall |=> o_valid && $stable(o_pixel_out), "stalled pixel changed")

    // The input side only backs up when the output is full and stalled.
    `HLCC_ASSERT(a_stall_cause, i_clk, i_rst_n,
        o_stall |-> o_valid && i_stall, "input stalled without output backpressure")

    // An accepted word reaches the output register if the receiver does not stall while it waits in the input register.
    `HLCC_ASSERT(a_latency, i_clk, i_rst_n,
        (i_valid && !o_stall) ##1 !i_stall |=> o_valid, "accepted word did not arrive")

endmodule

bind handheld_lcd_color_correction hlcc_checker u_hlcc_checker (.*);

// ===== test/hlcc_pixel_checker.sv =====
module hlcc_pixel_checker
    import hlcc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [15:0]       i_color_word,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [31:0]       i_pixel_out,
    output int                o_fail_count,
    output int                o_pending
);

    typedef struct packed {
        logic [15:0] word;
        logic [31:0] pixel;
    } t_pixel_expect;

    t_cfg          cfg_copy;
    t_pixel_expect pixel_q[$];
    t_pixel_expect head;
    int            fails;

    function automatic int brighten(input int c);
        int v;
        v = c;
        if (c != 0) begin
            v = (c < 16) ? c + 2 : c + 3;
        end
        return (v > 30) ? 30 : v;
    endfunction

    function automatic int darken(input int c);
        int cut;
        cut = (c < 25) ? 4 : 3;
        return (c > cut) ? c - cut : 0;
    endfunction

    function automatic logic [31:0] predict_pixel(input logic [15:0] word, input t_cfg cfg);
        int          r;
        int          g;
        int          b;
        int          rc;
        int          gc;
        int          bc;
        logic [63:0] wide;
        logic [31:0] px;
        r = int'(word[4:0]);
        g = int'(word[9:5]);
        b = int'(word[14:10]);
        case (cfg.color_mode)
            MODE_HANDHELD: begin
                rc = brighten(r);
                gc = brighten(g);
                bc = brighten(b);
                r  = (10 * rc + 3 * gc + bc) / 14;
                g  = (10 * gc + 2 * bc + 2 * rc) / 14;
                b  = (10 * bc + 2 * rc + 2 * gc) / 14;
            end
            MODE_ADVANCE: begin
                rc = darken(r);
                gc = darken(g);
                bc = darken(b);
                r  = (12 * rc + gc + bc) / 14;
                g  = (12 * gc + bc + rc) / 14;
                b  = (12 * bc + rc + gc) / 14;
            end
            default: begin
                // The undefined mode falls through to passthrough as well.
            end
        endcase
        // Bits pushed beyond bit 31 by a large shift are simply lost.
        wide = (64'(r) << cfg.red_shift) | (64'(g) << cfg.green_shift)
             | (64'(b) << cfg.blue_shift);
        px = wide[31:0];
        if (cfg.narrow_output) begin
            px[31:16] = '0;
        end
        return px;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_copy = CFG_RESET;
            pixel_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[ADDR_W-1:2])
                    REG_COLOR_MODE:    cfg_copy.color_mode    = pwdata[1:0];
                    REG_RED_SHIFT:     cfg_copy.red_shift     = pwdata[4:0];
                    REG_GREEN_SHIFT:   cfg_copy.green_shift   = pwdata[4:0];
                    REG_BLUE_SHIFT:    cfg_copy.blue_shift    = pwdata[4:0];
                    REG_NARROW_OUTPUT: cfg_copy.narrow_output = pwdata[0];
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                pixel_q.push_back('{word: i_color_word,
                                    pixel: predict_pixel(i_color_word, cfg_copy)});
            end
            if (i_out_valid && !i_out_stall) begin
                if (pixel_q.size() == 0) begin
                    $display("%0t: pixel word with nothing expected: expected none, got %h",
                             $time, i_pixel_out);
                    fails = fails + 1;
                end else begin
                    head = pixel_q.pop_front();
                    if (head.pixel !== i_pixel_out) begin
                        $display("%0t: pixel for colour %h: expected %h, got %h",
                                 $time, head.word, head.pixel, i_pixel_out);
                        fails = fails + 1;
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= pixel_q.size();
    end

    initial begin
        fails        = 0;
        cfg_copy     = CFG_RESET;
        o_fail_count = 0;
        o_pending    = 0;
    end

endmodule

// ===== test/tb_handheld_lcd_color_correction.sv =====
module tb_handheld_lcd_color_correction;
    import hlcc_pkg::*;

    localparam t_mode      MODE_UNDEFINED     = 2'd3;
    localparam logic [2:0] REG_TOP_INDEX      = 3'd7;
    localparam int         WORDS_PER_SETTING  = 50;
    localparam int         SETTINGS_PER_PHASE = 5;
    localparam int         PHASES             = 3;
    localparam int         DRAIN_CYCLES       = 8;
    localparam int         CYCLE_LIMIT        = 200000;

    localparam logic [15:0] EDGE_WORDS [6] = '{
        16'h0000,
        16'hFFFF,
        16'h8000,
        {1'b0, 5'd30, 5'd16, 5'd15},
        {1'b1, 5'd4, 5'd25, 5'd24},
        {1'b0, 5'd31, 5'd3, 5'd1}
    };
    localparam t_mode EDGE_MODES [4] = '{MODE_PASS, MODE_HANDHELD, MODE_ADVANCE, MODE_UNDEFINED};
    // Channel values either side of the add, subtract and clamp thresholds.
    localparam logic [4:0] KNEE_VALUES [14] = '{
        5'd0, 5'd1, 5'd3, 5'd4, 5'd5, 5'd15, 5'd16,
        5'd24, 5'd25, 5'd27, 5'd28, 5'd29, 5'd30, 5'd31
    };

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              i_valid;
    logic              o_stall;
    logic [15:0]       i_color_word;
    logic              o_valid;
    logic              i_stall;
    logic [31:0]       o_pixel_out;

    int fail_count;
    int pending;
    int send_idle = 19;
    int recv_idle = 61;
    int cycles    = 0;

    handheld_lcd_color_correction u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_color_word (i_color_word),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_pixel_out  (o_pixel_out)
    );

    hlcc_pixel_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_color_word (i_color_word),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_pixel_out  (o_pixel_out),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_idle);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [15:0] pick_word();
        logic [4:0] chan [3];
        if ($urandom_range(0, 99) < 30) begin
            foreach (chan[k]) begin
                chan[k] = KNEE_VALUES[$urandom_range(0, 13)];
            end
            return {1'($urandom_range(0, 1)), chan[2], chan[1], chan[0]};
        end
        return 16'($urandom);
    endfunction

    task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Registers only change once every pixel in flight has come out.
    task automatic apply_setting(input t_mode mode, input t_shift red, input t_shift green,
                                 input t_shift blue, input logic narrow);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        write_reg(REG_COLOR_MODE, (32'($urandom) & ~32'h3) | 32'(mode));
        write_reg(REG_RED_SHIFT, (32'($urandom) & ~32'h1F) | 32'(red));
        write_reg(REG_GREEN_SHIFT, (32'($urandom) & ~32'h1F) | 32'(green));
        write_reg(REG_BLUE_SHIFT, (32'($urandom) & ~32'h1F) | 32'(blue));
        write_reg(REG_NARROW_OUTPUT, (32'($urandom) & ~32'h1) | 32'(narrow));
        // A write past the last register must leave everything unchanged.
        write_reg(3'($urandom_range(REG_NARROW_OUTPUT + 1, REG_TOP_INDEX)), 32'($urandom));
    endtask

    task automatic send_word(input logic [15:0] word);
        while ($urandom_range(0, 99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_color_word <= word;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        i_valid      <= 1'b0;
        i_color_word <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (EDGE_MODES[m]) begin
            apply_setting(EDGE_MODES[m], CFG_RESET.red_shift, CFG_RESET.green_shift,
                          CFG_RESET.blue_shift, CFG_RESET.narrow_output);
            foreach (EDGE_WORDS[w]) begin
                send_word(EDGE_WORDS[w]);
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    send_idle = 19;
                    recv_idle = 61;
                end
                1: begin
                    send_idle = 61;
                    recv_idle = 19;
                end
                default: begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            for (int s = 0; s < SETTINGS_PER_PHASE; s++) begin
                case (phase * SETTINGS_PER_PHASE + s)
                    0: apply_setting(MODE_HANDHELD, 5'd31, 5'd31, 5'd31, 1'b0);
                    1: apply_setting(MODE_ADVANCE, 5'd0, 5'd0, 5'd0, 1'b1);
                    2: apply_setting(MODE_PASS, 5'd27, 5'd27, 5'd27, 1'b0);
                    3: apply_setting(MODE_UNDEFINED, 5'd16, 5'd21, 5'd26, 1'b1);
                    4: apply_setting(MODE_HANDHELD, 5'd27, 5'd11, 5'd0, 1'b1);
                    default: apply_setting(t_mode'($urandom_range(0, 3)),
                                           t_shift'($urandom_range(0, 31)),
                                           t_shift'($urandom_range(0, 31)),
                                           t_shift'($urandom_range(0, 31)),
                                           1'($urandom_range(0, 1)));
                endcase
                repeat (WORDS_PER_SETTING) send_word(pick_word());
            end
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/hlcc_pkg.sv
rtl/core/hlcc_mix.sv
rtl/core/handheld_lcd_color_correction.sv
rtl/core/hlcc_checker.sv
test/hlcc_pixel_checker.sv
test/tb_handheld_lcd_color_correction.sv
